/* src/gfd_pkg.sv */
// Shared types and constants of the Goertzel FSK demodulator.
package gfd_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int COEFF_W             = 17;
  localparam int CHUNK_W             = 16;
  localparam int BYTE_W              = 8;
  localparam int BIT_CNT_W           = 3;
  localparam int CFG_IDX_W           = 2;
  localparam int DIGIT_W             = 16;
  localparam int DIG_LOG             = 4;
  // Enough digit indexes for every accumulator width in the supported range.
  localparam int DIG_IDX_W           = 3;
  localparam int ACC_WIDTH_DEF       = 48;
  localparam int COEFF_FRAC_BITS_DEF = 14;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK      = 2'd2;

  typedef enum logic [1:0] {
    XS_QL1,
    XS_QL2,
    XS_QH1,
    XS_QH2
  } x_sel_t;

  typedef enum logic [1:0] {
    YS_COEF_L,
    YS_COEF_H,
    YS_DIG_Q,
    YS_DIG_T
  } y_sel_t;

  typedef struct packed {
    logic                 load;
    x_sel_t               x_sel;
    y_sel_t               y_sel;
    logic [DIG_IDX_W-1:0] dig;
    logic                 acc_pend;
    logic                 acc_neg;
    logic                 acc_frac;
    logic                 acc_clr;
    logic                 upd_low;
    logic                 upd_high;
    logic                 idx_inc;
    logic                 t_load;
    logic                 push_bit;
    logic                 out_load;
    logic                 clr_rec;
  } gfd_cmd_t;

  typedef struct packed {
    logic chunk_end;
    logic byte_full;
  } gfd_sts_t;

endpackage

/* src/goertzel_fsk_demodulator_top.sv */
// Top level of the two-tone Goertzel FSK demodulator.
// Once a sample is accepted, ST_REC_L, ST_REC_H and ST_REC_U run before the
// next one can be taken. A sample that closes a chunk also passes ST_SQ, then
// ST_XC_M, ST_XC_T and ST_XC_D per tone, ST_DRAIN and ST_BIT, on the one
// shared 17-bit by A-bit multiplier; a finished byte may wait for the output.
// Reset (rst_n low, synchronous) clears control, recursions and config; chunk length resets to 1.
module goertzel_fsk_demodulator_top
  import gfd_pkg::*;
#(
  parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic signed [SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic                       in_tuser,   // [0] start_message
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [BYTE_W-1:0]          out_tdata,  // [7:0] byte_value
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEFF_W-1:0]         cfg_data
);

  gfd_cmd_t cmd;
  gfd_sts_t sts;

  gfd_ctrl #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gfd_datapath #(
    .ACC_WIDTH       (ACC_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_tdata),
    .in_start  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_byte  (out_tdata)
  );

endmodule

/* src/gfd_datapath.sv */
// Datapath: registers, recursions, shared multiplier and power accumulator.
module gfd_datapath
  import gfd_pkg::*;
#(
  parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEFF_W-1:0]         cfg_data,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_start,
  input  gfd_cmd_t                   cmd,
  output gfd_sts_t                   sts,
  output logic [BYTE_W-1:0]          out_byte
);

  localparam int PR_W   = ACC_WIDTH + COEFF_W;
  localparam int N_DIG  = (ACC_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int N_DIGT = (PR_W + DIGIT_W - 1) / DIGIT_W;
  localparam int QP_W   = N_DIG * DIGIT_W;
  localparam int TP_W   = N_DIGT * DIGIT_W;
  localparam int DW     = 2 * ACC_WIDTH + COEFF_FRAC_BITS + 18;
  localparam int SH_W   = $clog2(DW);

  logic signed [COEFF_W-1:0]   coeff_low_r, coeff_high_r;
  logic [CHUNK_W-1:0]          chunk_r;
  logic signed [ACC_WIDTH-1:0] ql1_r, ql2_r, qh1_r, qh2_r;
  logic [CHUNK_W-1:0]          idx_r;
  logic [BYTE_W-1:0]           shift_r;
  logic [BIT_CNT_W-1:0]        bidx_r;
  logic                        pend_r;
  logic                        pend_neg_r;
  logic                        pend_frac_r;
  logic [DIG_IDX_W-1:0]        pend_dig_r;

  logic signed [SAMPLE_W-1:0]  smp_r;
  logic signed [PR_W-1:0]      pr_r;
  logic signed [PR_W-1:0]      t_r;
  logic signed [DW-1:0]        acc_r;
  logic [BYTE_W-1:0]           out_byte_r;

  logic signed [ACC_WIDTH-1:0] x_op;
  logic signed [COEFF_W-1:0]   y_op;
  logic [QP_W-1:0]             xpad;
  logic [TP_W-1:0]             tpad;
  logic signed [PR_W-1:0]      pr_sh;
  logic signed [ACC_WIDTH-1:0] q0_low, q0_high;
  logic [SH_W-1:0]             shamt;
  logic signed [DW-1:0]        addend;
  logic [CHUNK_W:0]            count, limit;
  logic                        bit_val;
  logic [BYTE_W-1:0]           shift_new;

  always_comb begin
    unique case (cmd.x_sel)
      XS_QL1:  x_op = ql1_r;
      XS_QL2:  x_op = ql2_r;
      XS_QH1:  x_op = qh1_r;
      XS_QH2:  x_op = qh2_r;
      default: x_op = ql1_r;
    endcase
  end

  assign xpad = QP_W'(x_op);
  assign tpad = TP_W'(t_r);

  // Lower digits are unsigned, the top digit carries the sign.
  always_comb begin
    y_op = '0;
    unique case (cmd.y_sel)
      YS_COEF_L: y_op = coeff_low_r;
      YS_COEF_H: y_op = coeff_high_r;
      YS_DIG_Q: begin
        for (int i = 0; i < N_DIG; i++) begin
          if (cmd.dig == DIG_IDX_W'(i)) begin
            if (i == N_DIG - 1) y_op = {xpad[QP_W-1], xpad[i*DIGIT_W +: DIGIT_W]};
            else                y_op = {1'b0, xpad[i*DIGIT_W +: DIGIT_W]};
          end
        end
      end
      YS_DIG_T: begin
        for (int i = 0; i < N_DIGT; i++) begin
          if (cmd.dig == DIG_IDX_W'(i)) begin
            if (i == N_DIGT - 1) y_op = {tpad[TP_W-1], tpad[i*DIGIT_W +: DIGIT_W]};
            else                 y_op = {1'b0, tpad[i*DIGIT_W +: DIGIT_W]};
          end
        end
      end
      default: y_op = '0;
    endcase
  end

  // In the update state the product register holds the coefficient product of
  // the tone being updated, since the recursion reads it in the next cycle.
  assign pr_sh   = pr_r >>> COEFF_FRAC_BITS;
  assign q0_low  = pr_sh[ACC_WIDTH-1:0] - ql2_r + ACC_WIDTH'(smp_r);
  assign q0_high = pr_sh[ACC_WIDTH-1:0] - qh2_r + ACC_WIDTH'(smp_r);

  assign shamt  = (SH_W'(pend_dig_r) << DIG_LOG)
                + (pend_frac_r ? SH_W'(COEFF_FRAC_BITS) : '0);
  assign addend = DW'(pr_r) <<< shamt;

  assign count = {1'b0, idx_r} + 1'b1;
  assign limit = (chunk_r == '0) ? {1'b1, {CHUNK_W{1'b0}}} : {1'b0, chunk_r};

  assign sts.chunk_end = (count >= limit);
  assign sts.byte_full = (bidx_r == '1);

  assign bit_val   = !acc_r[DW-1] && (acc_r != '0);
  assign shift_new = {shift_r[BYTE_W-2:0], bit_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_low_r  <= '0;
      coeff_high_r <= '0;
      chunk_r      <= CHUNK_W'(1);
      ql1_r        <= '0;
      ql2_r        <= '0;
      qh1_r        <= '0;
      qh2_r        <= '0;
      idx_r        <= '0;
      shift_r      <= '0;
      bidx_r       <= '0;
      pend_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEFF_LOW:  coeff_low_r  <= cfg_data;
          REG_COEFF_HIGH: coeff_high_r <= cfg_data;
          REG_CHUNK:      chunk_r      <= cfg_data[CHUNK_W-1:0];
          default:        ;
        endcase
      end

      pend_r <= cmd.acc_pend;

      priority if ((cmd.load && in_start) || cmd.clr_rec) begin
        ql1_r <= '0;
        ql2_r <= '0;
        qh1_r <= '0;
        qh2_r <= '0;
        idx_r <= '0;
      end else begin
        if (cmd.upd_low) begin
          ql1_r <= q0_low;
          ql2_r <= ql1_r;
        end
        if (cmd.upd_high) begin
          qh1_r <= q0_high;
          qh2_r <= qh1_r;
        end
        if (cmd.idx_inc) idx_r <= count[CHUNK_W-1:0];
      end

      priority if (cmd.load && in_start) begin
        shift_r <= '0;
        bidx_r  <= '0;
      end else if (cmd.push_bit) begin
        shift_r <= cmd.out_load ? '0 : shift_new;
        bidx_r  <= bidx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pr_r        <= PR_W'(x_op) * PR_W'(y_op);
    pend_neg_r  <= cmd.acc_neg;
    pend_frac_r <= cmd.acc_frac;
    pend_dig_r  <= cmd.dig;
    if (cmd.load)     smp_r      <= in_sample;
    if (cmd.t_load)   t_r        <= pr_r;
    if (cmd.out_load) out_byte_r <= shift_new;
    priority if (cmd.acc_clr) acc_r <= '0;
    else if (pend_r)          acc_r <= pend_neg_r ? acc_r - addend : acc_r + addend;
  end

  assign out_byte = out_byte_r;

endmodule

/* src/gfd_ctrl.sv */
// Controller: sequences the recursions per sample and the power comparison per chunk.
module gfd_ctrl
  import gfd_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  gfd_sts_t sts,
  output gfd_cmd_t cmd
);

  localparam int N_DIG  = (ACC_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int N_DIGT = (ACC_WIDTH + COEFF_W + DIGIT_W - 1) / DIGIT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_L,
    ST_REC_H,
    ST_REC_U,
    ST_SQ,
    ST_XC_M,
    ST_XC_T,
    ST_XC_D,
    ST_DRAIN,
    ST_BIT
  } state_t;

  state_t               state_r, state_nxt;
  x_sel_t               opd_r, opd_nxt;
  logic                 tone_r, tone_nxt;
  logic [DIG_IDX_W-1:0] dig_r, dig_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_busy;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_busy   = out_tvalid_r && !out_tready;

  always_comb begin
    cmd            = '0;
    cmd.x_sel      = XS_QL1;
    cmd.y_sel      = YS_COEF_L;
    state_nxt      = state_r;
    opd_nxt        = opd_r;
    tone_nxt       = tone_r;
    dig_nxt        = dig_r;
    out_tvalid_nxt = out_busy;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_REC_L;
        end
      end
      ST_REC_L: begin
        cmd.x_sel = XS_QL1;
        cmd.y_sel = YS_COEF_L;
        state_nxt = ST_REC_H;
      end
      ST_REC_H: begin
        cmd.x_sel   = XS_QH1;
        cmd.y_sel   = YS_COEF_H;
        cmd.upd_low = 1'b1;
        state_nxt   = ST_REC_U;
      end
      ST_REC_U: begin
        cmd.upd_high = 1'b1;
        if (sts.chunk_end) begin
          cmd.acc_clr = 1'b1;
          opd_nxt     = XS_QL1;
          tone_nxt    = 1'b0;
          dig_nxt     = '0;
          state_nxt   = ST_SQ;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SQ: begin
        // Squares of all four recursion values, digit by digit; the
        // low tone's terms are subtracted from the difference.
        cmd.x_sel    = opd_r;
        cmd.y_sel    = YS_DIG_Q;
        cmd.dig      = dig_r;
        cmd.acc_pend = 1'b1;
        cmd.acc_frac = 1'b1;
        cmd.acc_neg  = (opd_r == XS_QL1) || (opd_r == XS_QL2);
        if (dig_r == DIG_IDX_W'(N_DIG - 1)) begin
          dig_nxt = '0;
          unique case (opd_r)
            XS_QL1:  opd_nxt = XS_QL2;
            XS_QL2:  opd_nxt = XS_QH1;
            XS_QH1:  opd_nxt = XS_QH2;
            XS_QH2:  state_nxt = ST_XC_M;
            default: opd_nxt = XS_QL1;
          endcase
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      ST_XC_M: begin
        cmd.x_sel = tone_r ? XS_QH1 : XS_QL1;
        cmd.y_sel = tone_r ? YS_COEF_H : YS_COEF_L;
        state_nxt = ST_XC_T;
      end
      ST_XC_T: begin
        cmd.t_load = 1'b1;
        state_nxt  = ST_XC_D;
      end
      ST_XC_D: begin
        cmd.x_sel    = tone_r ? XS_QH2 : XS_QL2;
        cmd.y_sel    = YS_DIG_T;
        cmd.dig      = dig_r;
        cmd.acc_pend = 1'b1;
        cmd.acc_neg  = tone_r;
        if (dig_r == DIG_IDX_W'(N_DIGT - 1)) begin
          dig_nxt = '0;
          if (tone_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            tone_nxt  = 1'b1;
            state_nxt = ST_XC_M;
          end
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_BIT;
      end
      ST_BIT: begin
        // A finished byte waits here while the previous request is unread.
        if (!(sts.byte_full && out_busy)) begin
          cmd.push_bit = 1'b1;
          cmd.clr_rec  = 1'b1;
          if (sts.byte_full) begin
            cmd.out_load   = 1'b1;
            out_tvalid_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      opd_r        <= XS_QL1;
      tone_r       <= 1'b0;
      dig_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      opd_r        <= opd_nxt;
      tone_r       <= tone_nxt;
      dig_r        <= dig_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a sample is still being processed");

  a_valid_from_bit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_BIT))
    else $error("output request raised outside the bit decision");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIT && sts.byte_full && out_busy) |-> !cmd.out_load)
    else $error("pending output byte overwritten");

endmodule
